// ----- rtl/uvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, constants and helpers for the UV-sphere vertex pipeline.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_SEGMENTS    = 1024;
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_FRAC_BITS = 14;
  localparam int SEG_W           = 11;
  localparam int NUM_W           = 27;
  localparam int QUO_W           = 18;
  localparam int DIV_STEPS       = 6;
  localparam int DIV_BITS        = 3;
  localparam int HORNER_STEPS    = 6;
  localparam int HSTAGES         = 3 * HORNER_STEPS;
  localparam int LAST_STAGE      = 31;

  // configuration register indexes
  localparam logic [1:0] CFG_LON = 2'd0;
  localparam logic [1:0] CFG_LAT = 2'd1;

  localparam logic [SEG_W-1:0] SEG_RESET = 11'd64;
  localparam logic [SEG_W-1:0] SEG_MAX   = 11'(MAX_SEGMENTS);

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Horner divisors for k = 6 down to 1, and floor(2^32 / d)
  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
    32'd27531841, 32'd39045157, 32'd59652323,
    32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
    32'd32537631, 32'd47721858, 32'd76695844,
    32'd143165576, 32'd357913941, 32'd2147483648};

  // Three restoring division steps: returns {remainder, quotient bits}
  function automatic logic [SEG_W+DIV_BITS-1:0] div3(
    input logic [SEG_W-1:0]    rem,
    input logic [DIV_BITS-1:0] bits,
    input logic [SEG_W-1:0]    den
  );
    logic [SEG_W:0]      r12;
    logic [SEG_W-1:0]    r;
    logic [DIV_BITS-1:0] q;
    r = rem;
    q = '0;
    for (int j = DIV_BITS - 1; j >= 0; j--) begin
      r12 = {r, bits[j]};
      if (r12 >= {1'b0, den}) begin
        r12  = r12 - {1'b0, den};
        q[j] = 1'b1;
      end
      r = r12[SEG_W-1:0];
    end
    return {r, q};
  endfunction

endpackage

// ----- rtl/uv_sphere_vertex_position.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_position
// Maps a (column, row) grid point to a unit-sphere point in signed Q1.14.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | cfg_we, cfg_index, cfg_data               | in
//  grid in  | in_valid, in_ready, col_index, row_index  | in
//  vertex   | out_valid, out_ready, pos_x, pos_y, pos_z | out
//
// One grid point per cycle while the output is not stalled, through a pipeline of
// capture, six 3-bit restoring divide stages, octant fold, angle and square
// multiplies, six Horner steps of three stages each, and four output stages.
// Reset clears the valid bits and sets both segment counts to 64.
// A stalled vertex at the output holds every stage, empty ones included;
// in_ready is high whenever the output slot can advance.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_position (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [uvs_pkg::SEG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [uvs_pkg::SEG_W-1:0]    col_index,
  input  logic [uvs_pkg::SEG_W-1:0]    row_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           pos_x,
  output logic signed [15:0]           pos_y,
  output logic signed [15:0]           pos_z
);

  localparam int L  = uvs_pkg::LAST_STAGE;
  localparam int SW = uvs_pkg::SEG_W;
  localparam int HS = uvs_pkg::HSTAGES;
  localparam int HN = uvs_pkg::HORNER_STEPS;
  localparam int DS = uvs_pkg::DIV_STEPS;

  logic [SW-1:0] lon_segments, lat_segments;
  logic [L:0]    vld;
  logic          en;

  // capture-stage logic
  logic [SW-1:0] nlon, nlat, col_sat, row_sat;
  logic [uvs_pkg::NUM_W-1:0] num_lon, num_lat;

  // divider pipeline, unit 0 longitude, unit 1 latitude
  logic [SW-1:0]              dv_rem [2][DS+1];
  logic [uvs_pkg::QUO_W-1:0]  dv_low [2][DS+1];
  logic [uvs_pkg::QUO_W-1:0]  dv_quo [2][DS+1];
  logic [SW-1:0]              dv_den [2][DS+1];

  // fold, angle and square stages
  logic [13:0] f_rr [2];
  logic        f_sw [2];
  logic [1:0]  f_q  [2];
  logic [29:0] t_t  [2];
  logic        t_sw [2];
  logic [1:0]  t_q  [2];

  // side band through the Horner stages; index 0 is the square stage
  logic [29:0] hb_t  [2][HS+1];
  logic [29:0] hb_u  [2][HS+1];
  logic        hb_sw [2][HS+1];
  logic [1:0]  hb_q  [2][HS+1];

  // Horner stages, chain 0 sine, chain 1 cosine
  logic [60:0] hr_p    [2][2][HN];
  logic [29:0] hr_x    [2][2][HN];
  logic [61:0] hr_m    [2][2][HN];
  logic [30:0] hr_h    [2][2][HN];
  logic [30:0] h_in    [2][2][HN];
  logic [30:0] h_next  [2][2][HN];

  // final sine/cosine, quadrant, product and output stages
  logic [29:0] s_s  [2];
  logic [30:0] s_c  [2];
  logic        s_sw [2];
  logic [1:0]  s_q  [2];
  logic [30:0] q_sm [2];
  logic [30:0] q_cm [2];
  logic        q_sn [2];
  logic        q_cn [2];
  logic [61:0] p_x, p_z;
  logic [30:0] p_y;
  logic        p_xn, p_yn, p_zn;
  logic [14:0] mag_x, mag_y, mag_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lon_segments <= uvs_pkg::SEG_RESET;
      lat_segments <= uvs_pkg::SEG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::CFG_LON: lon_segments <= cfg_data;
        uvs_pkg::CFG_LAT: lat_segments <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the whole pipeline unless the output transfer is stalled
  assign en        = !vld[L] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[L];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-1:0], in_valid};
    end
  end

  // clamp counts, saturate indexes, form rounded numerators
  always_comb begin
    nlon = (lon_segments == '0) ? SW'(1) :
           (lon_segments > uvs_pkg::SEG_MAX) ? uvs_pkg::SEG_MAX : lon_segments;
    nlat = (lat_segments == '0) ? SW'(1) :
           (lat_segments > uvs_pkg::SEG_MAX) ? uvs_pkg::SEG_MAX : lat_segments;
    col_sat = (col_index > nlon) ? nlon : col_index;
    row_sat = (row_index > nlat) ? nlat : row_index;
    num_lon = {col_sat, 16'b0} + uvs_pkg::NUM_W'(nlon >> 1);
    num_lat = {1'b0, row_sat, 15'b0} + uvs_pkg::NUM_W'(nlat >> 1);
  end

  // Horner step: pick incoming h, then correct the reciprocal quotient
  always_comb begin
    logic [29:0] qe;
    logic [29:0] rm;
    logic [29:0] qd;
    logic [7:0]  d;
    qe = '0;
    rm = '0;
    qd = '0;
    d  = '0;
    for (int u = 0; u < 2; u++) begin
      for (int c = 0; c < 2; c++) begin
        h_in[u][c][0] = uvs_pkg::Q30_ONE;
        for (int i = 1; i < HN; i++) begin
          h_in[u][c][i] = hr_h[u][c][i-1];
        end
        for (int i = 0; i < HN; i++) begin
          d  = (c == 0) ? uvs_pkg::SIN_DIV[i] : uvs_pkg::COS_DIV[i];
          qe = hr_m[u][c][i][61:32];
          qd = 30'(38'(qe) * 38'(d));
          rm = hr_x[u][c][i] - qd;
          if (rm >= 30'(d)) begin
            qe = qe + 30'd1;
          end
          h_next[u][c][i] = uvs_pkg::Q30_ONE - 31'(qe);
        end
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      // capture: split numerator into initial remainder and low bits
      dv_rem[0][0] <= SW'(num_lon[uvs_pkg::NUM_W-1:uvs_pkg::QUO_W]);
      dv_low[0][0] <= num_lon[uvs_pkg::QUO_W-1:0];
      dv_den[0][0] <= nlon;
      dv_quo[0][0] <= '0;
      dv_rem[1][0] <= SW'(num_lat[uvs_pkg::NUM_W-1:uvs_pkg::QUO_W]);
      dv_low[1][0] <= num_lat[uvs_pkg::QUO_W-1:0];
      dv_den[1][0] <= nlat;
      dv_quo[1][0] <= '0;

      for (int u = 0; u < 2; u++) begin
        // divide, three quotient bits per stage
        for (int s = 1; s <= DS; s++) begin
          {dv_rem[u][s], dv_quo[u][s][2:0]} <=
            uvs_pkg::div3(dv_rem[u][s-1], dv_low[u][s-1][uvs_pkg::QUO_W-1 -: 3],
                          dv_den[u][s-1]);
          dv_quo[u][s][uvs_pkg::QUO_W-1:3] <= dv_quo[u][s-1][uvs_pkg::QUO_W-4:0];
          dv_low[u][s] <= {dv_low[u][s-1][uvs_pkg::QUO_W-4:0], 3'b0};
          dv_den[u][s] <= dv_den[u][s-1];
        end

        // fold the phase into the first octant
        f_q[u] <= dv_quo[u][DS][15:14];
        if (dv_quo[u][DS][13:0] <= 14'd8192) begin
          f_rr[u] <= dv_quo[u][DS][13:0];
          f_sw[u] <= 1'b0;
        end else begin
          f_rr[u] <= 14'(15'd16384 - {1'b0, dv_quo[u][DS][13:0]});
          f_sw[u] <= 1'b1;
        end

        // octant angle in Q30 radians
        t_t[u]  <= 30'((45'(f_rr[u]) * 45'(uvs_pkg::HALF_PI_Q30) + 45'd8192) >> 14);
        t_sw[u] <= f_sw[u];
        t_q[u]  <= f_q[u];

        // square of the angle
        hb_u[u][0]  <= 30'((60'(t_t[u]) * 60'(t_t[u]) + 60'h2000_0000) >> 30);
        hb_t[u][0]  <= t_t[u];
        hb_sw[u][0] <= t_sw[u];
        hb_q[u][0]  <= t_q[u];

        for (int n = 1; n <= HS; n++) begin
          hb_u[u][n]  <= hb_u[u][n-1];
          hb_t[u][n]  <= hb_t[u][n-1];
          hb_sw[u][n] <= hb_sw[u][n-1];
          hb_q[u][n]  <= hb_q[u][n-1];
        end

        // Horner steps: multiply, reciprocal multiply, correct
        for (int c = 0; c < 2; c++) begin
          for (int i = 0; i < HN; i++) begin
            hr_p[u][c][i] <= 61'(hb_u[u][3*i]) * 61'(h_in[u][c][i]);
            hr_x[u][c][i] <= hr_p[u][c][i][59:30];
            hr_m[u][c][i] <= 62'(hr_p[u][c][i][59:30]) *
                             62'((c == 0) ? uvs_pkg::SIN_RCP[i] : uvs_pkg::COS_RCP[i]);
            hr_h[u][c][i] <= h_next[u][c][i];
          end
        end

        // sine = t * h, cosine = h
        s_s[u]  <= 30'((61'(hb_t[u][HS]) * 61'(hr_h[u][0][HN-1])) >> 30);
        s_c[u]  <= hr_h[u][1][HN-1];
        s_sw[u] <= hb_sw[u][HS];
        s_q[u]  <= hb_q[u][HS];

        // undo the octant swap and apply quadrant signs
        begin
          logic [30:0] sa, ca;
          sa = s_sw[u] ? s_c[u] : {1'b0, s_s[u]};
          ca = s_sw[u] ? {1'b0, s_s[u]} : s_c[u];
          case (s_q[u])
            2'd0: begin
              q_sm[u] <= sa; q_sn[u] <= 1'b0; q_cm[u] <= ca; q_cn[u] <= 1'b0;
            end
            2'd1: begin
              q_sm[u] <= ca; q_sn[u] <= 1'b0; q_cm[u] <= sa; q_cn[u] <= 1'b1;
            end
            2'd2: begin
              q_sm[u] <= sa; q_sn[u] <= 1'b1; q_cm[u] <= ca; q_cn[u] <= 1'b1;
            end
            default: begin
              q_sm[u] <= ca; q_sn[u] <= 1'b1; q_cm[u] <= sa; q_cn[u] <= 1'b0;
            end
          endcase
        end
      end

      // coordinate products in Q60; y carries the latitude cosine in Q30
      p_x  <= 62'(q_cm[0]) * 62'(q_sm[1]);
      p_z  <= 62'(q_sm[0]) * 62'(q_sm[1]);
      p_y  <= q_cm[1];
      p_xn <= q_cn[0] ^ q_sn[1];
      p_zn <= q_sn[0] ^ q_sn[1];
      p_yn <= q_cn[1];

      // round half away from zero and apply sign
      pos_x <= p_xn ? (16'sd0 - signed'({1'b0, mag_x})) : signed'({1'b0, mag_x});
      pos_y <= p_yn ? (16'sd0 - signed'({1'b0, mag_y})) : signed'({1'b0, mag_y});
      pos_z <= p_zn ? (16'sd0 - signed'({1'b0, mag_z})) : signed'({1'b0, mag_z});
    end
  end

  assign mag_x = 15'((p_x + 62'h2000_0000_0000) >> 46);
  assign mag_z = 15'((p_z + 62'h2000_0000_0000) >> 46);
  assign mag_y = 15'((p_y + 31'h8000) >> 16);

endmodule
